@@ src/chp_pkg.sv @@
package chp_pkg;

  // Parse phase codes, as reported on the phase output.
  localparam logic [3:0] PH_SIZE_WS  = 4'd0;
  localparam logic [3:0] PH_SIZE     = 4'd1;
  localparam logic [3:0] PH_EXT_WS   = 4'd2;
  localparam logic [3:0] PH_EXT      = 4'd3;
  localparam logic [3:0] PH_AWAIT_LF = 4'd4;
  localparam logic [3:0] PH_VALID    = 4'd5;
  localparam logic [3:0] PH_ERR_LEN  = 4'd6;
  localparam logic [3:0] PH_ERR_WS   = 4'd7;
  localparam logic [3:0] PH_ERR_SIZE = 4'd8;
  localparam logic [3:0] PH_ERR_CRLF = 4'd9;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_LINE_LENGTH = 2'd0;
  localparam logic [1:0] CFG_MAX_WHITESPACE  = 2'd1;
  localparam logic [1:0] CFG_MAX_CHUNK_LEN   = 2'd2;
  localparam logic [1:0] CFG_STRICT_CRLF     = 2'd3;

  // Configuration reset values.
  localparam logic [15:0] RST_MAX_LINE_LENGTH = 16'd1024;
  localparam logic [7:0]  RST_MAX_WHITESPACE  = 8'd8;
  localparam logic [63:0] RST_MAX_CHUNK_LEN   = 64'h0000_0000_FFFF_FFFF;

  // Characters of interest.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef struct packed {
    logic [15:0] max_line_length;
    logic [7:0]  max_whitespace;
    logic [63:0] max_chunk_len;
    logic        strict_crlf;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] line_count;
    logic [7:0]  space_count;
    logic [4:0]  digit_count;
    logic [63:0] size_accum;
    logic        size_done;
  } parse_state_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  phase;
    logic [63:0] chunk_len;
    logic        size_known;
    logic        ext_byte;
    logic        header_done;
  } result_t;

endpackage

@@ src/chp_cfg_regs.sv @@
module chp_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [63:0]   cfg_data_i,
  output chp_pkg::cfg_t cfg_o
);
  import chp_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index of a write transfer.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_LINE_LENGTH: cfg_d.max_line_length = cfg_data_i[15:0];
        CFG_MAX_WHITESPACE:  cfg_d.max_whitespace  = cfg_data_i[7:0];
        CFG_MAX_CHUNK_LEN:   cfg_d.max_chunk_len   = cfg_data_i;
        CFG_STRICT_CRLF:     cfg_d.strict_crlf     = cfg_data_i[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_line_length <= RST_MAX_LINE_LENGTH;
      cfg_q.max_whitespace  <= RST_MAX_WHITESPACE;
      cfg_q.max_chunk_len   <= RST_MAX_CHUNK_LEN;
      cfg_q.strict_crlf     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/chp_step.sv @@
module chp_step #(
  parameter int unsigned MaxHexDigits = 16
) (
  input  chp_pkg::cfg_t         cfg_i,
  input  chp_pkg::parse_state_t state_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  restart_i,
  output chp_pkg::parse_state_t state_o,
  output chp_pkg::result_t      result_o
);
  import chp_pkg::*;

  localparam logic [4:0] DigitLimit = 5'(MaxHexDigits);

  parse_state_t cur;
  parse_state_t nxt;
  logic         is_ws, is_cr, is_lf, is_semi, is_hex;
  logic [3:0]   hex_val;
  logic         overflow;
  logic         go_size, go_ext;
  logic         ok, ext;

  // Character classes.
  always_comb begin
    is_ws   = (in_byte_i == CH_SPACE) || (in_byte_i == CH_TAB);
    is_cr   = (in_byte_i == CH_CR);
    is_lf   = (in_byte_i == CH_LF);
    is_semi = (in_byte_i == CH_SEMI);
    is_hex  = 1'b0;
    hex_val = in_byte_i[3:0];
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      is_hex = 1'b1;
    end else if ((in_byte_i >= 8'h61 && in_byte_i <= 8'h66) ||
                 (in_byte_i >= 8'h41 && in_byte_i <= 8'h46)) begin
      is_hex  = 1'b1;
      hex_val = in_byte_i[3:0] + 4'd9;
    end
  end

  // A restart clears the parser before the byte is handled.
  assign cur = restart_i ? '0 : state_i;

  // Per-byte parse decision.
  always_comb begin
    nxt     = cur;
    ok      = 1'b0;
    ext     = 1'b0;
    go_size = 1'b0;
    go_ext  = 1'b0;

    // Saturating line length counter.
    overflow = (cur.line_count == 16'hFFFF);
    if (!overflow) begin
      nxt.line_count = cur.line_count + 16'd1;
    end
    if (overflow || (nxt.line_count > cfg_i.max_line_length)) begin
      nxt.phase = PH_ERR_LEN;
    end

    unique case (nxt.phase)
      PH_SIZE_WS: begin
        if (is_ws) begin
          if (cur.space_count >= cfg_i.max_whitespace) begin
            nxt.phase = PH_ERR_WS;
          end else begin
            nxt.space_count = cur.space_count + 8'd1;
            ok = 1'b1;
          end
        end else begin
          go_size = 1'b1;
        end
      end
      PH_SIZE:     go_size = 1'b1;
      PH_EXT_WS: begin
        if (is_ws) begin
          if (cur.space_count < cfg_i.max_whitespace) begin
            nxt.space_count = cur.space_count + 8'd1;
            ok = 1'b1;
          end
        end else begin
          go_ext = 1'b1;
        end
      end
      PH_EXT:      go_ext = 1'b1;
      PH_AWAIT_LF: begin
        if (is_lf) begin
          nxt.phase = PH_VALID;
          ok = 1'b1;
        end
      end
      default:     ok = 1'b0;
    endcase

    // Hex size field.
    if (go_size) begin
      nxt.phase = PH_SIZE;
      if (is_hex) begin
        if (cur.digit_count >= DigitLimit) begin
          nxt.phase = PH_ERR_SIZE;
        end else begin
          nxt.digit_count = cur.digit_count + 5'd1;
          nxt.size_accum  = {cur.size_accum[59:0], hex_val};
          ok = 1'b1;
        end
      end else if (is_cr || is_lf || is_semi) begin
        nxt.size_done = 1'b1;
        if (cur.size_accum > cfg_i.max_chunk_len) begin
          nxt.phase = PH_ERR_SIZE;
        end else if (is_semi) begin
          nxt.space_count = '0;
          nxt.phase = PH_EXT_WS;
          ok = 1'b1;
        end else if (is_cr) begin
          nxt.phase = PH_AWAIT_LF;
          ok = 1'b1;
        end else if (!cfg_i.strict_crlf) begin
          nxt.phase = PH_VALID;
          ok = 1'b1;
        end
      end
    end

    // Extension text, flagged and dropped.
    if (go_ext) begin
      nxt.phase = PH_EXT;
      ok = 1'b1;
      if (!is_cr && !is_lf) begin
        ext = 1'b1;
      end else if (is_cr) begin
        nxt.phase = PH_AWAIT_LF;
      end else if (cfg_i.strict_crlf) begin
        nxt.phase = PH_ERR_CRLF;
        ok = 1'b0;
      end else begin
        nxt.phase = PH_VALID;
      end
    end
  end

  assign state_o = nxt;

  always_comb begin
    result_o.accepted    = ok;
    result_o.phase       = nxt.phase;
    result_o.chunk_len   = nxt.size_accum;
    result_o.size_known  = nxt.size_done;
    result_o.ext_byte    = ext;
    result_o.header_done = (nxt.phase == PH_VALID);
  end

endmodule

@@ src/http_chunk_header_parser.sv @@
// Pipeline: each byte passes through the input register and then the result
// register, moving on only when the result register is free or draining.
// Throughput: one byte per cycle; the input stalls only while the result
// register holds a result that the receiver has not taken.
// Reset: configuration returns to its defaults and the parser state clears.
module http_chunk_header_parser #(
  parameter int unsigned MAX_HEX_DIGITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [3:0]  phase_o,
  output logic [63:0] chunk_len_o,
  output logic        size_known_o,
  output logic        ext_byte_o,
  output logic        header_done_o
);
  import chp_pkg::*;

  cfg_t         cfg;
  parse_state_t state_q, state_d;
  result_t      result_d, result_q;
  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         restart_q;
  logic         out_valid_q;
  logic         advance;

  assign cfg_ready_o = 1'b1;

  chp_cfg_regs u_cfg_regs (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  chp_step #(
    .MaxHexDigits (MAX_HEX_DIGITS)
  ) u_step (
    .cfg_i     (cfg),
    .state_i   (state_q),
    .in_byte_i (in_byte_q),
    .restart_i (restart_q),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  // The held byte moves on when the result register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      restart_q <= restart_i;
    end
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = result_q.accepted;
  assign phase_o       = result_q.phase;
  assign chunk_len_o   = result_q.chunk_len;
  assign size_known_o  = result_q.size_known;
  assign ext_byte_o    = result_q.ext_byte;
  assign header_done_o = result_q.header_done;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import chp_pkg::*;

  localparam int unsigned HEX_DIGIT_LIMIT = 16;

  // Tracks the parser state, predicts one result per byte transfer and
  // checks the results in order.
  class chunk_line_tracker;
    cfg_t         limits;
    parse_state_t st;
    result_t      expected_results[$];
    int unsigned  transfers;
    int unsigned  checked;
    int unsigned  failures;
    int unsigned  headers_done;
    int unsigned  refused;

    function new();
      limits.max_line_length = RST_MAX_LINE_LENGTH;
      limits.max_whitespace  = RST_MAX_WHITESPACE;
      limits.max_chunk_len   = RST_MAX_CHUNK_LEN;
      limits.strict_crlf     = 1'b0;
      clear_line();
    endfunction

    function void clear_line();
      st       = '0;
      st.phase = PH_SIZE_WS;
    endfunction

    function void set_register(logic [1:0] index, logic [63:0] data);
      case (index)
        CFG_MAX_LINE_LENGTH: limits.max_line_length = data[15:0];
        CFG_MAX_WHITESPACE:  limits.max_whitespace  = data[7:0];
        CFG_MAX_CHUNK_LEN:   limits.max_chunk_len   = data;
        CFG_STRICT_CRLF:     limits.strict_crlf     = data[0];
        default: ;
      endcase
    endfunction

    function int hex_value(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
    endfunction

    // Moves the parse phase on by one byte; returns whether the byte is taken.
    function logic advance(logic [7:0] c, output logic ext);
      int   digit;
      logic blank;
      ext   = 1'b0;
      digit = hex_value(c);
      blank = (c == CH_SPACE) || (c == CH_TAB);
      // Leading blanks are counted; anything else drops into the next field.
      if (st.phase == PH_SIZE_WS) begin
        if (blank) begin
          if (st.space_count >= limits.max_whitespace) begin
            st.phase = PH_ERR_WS;
            return 1'b0;
          end
          st.space_count = st.space_count + 8'd1;
          return 1'b1;
        end
        st.phase = PH_SIZE;
      end else if (st.phase == PH_EXT_WS) begin
        if (blank) begin
          if (st.space_count >= limits.max_whitespace) return 1'b0;
          st.space_count = st.space_count + 8'd1;
          return 1'b1;
        end
        st.phase = PH_EXT;
      end
      case (st.phase)
        PH_SIZE: begin
          if (digit >= 0) begin
            if (st.digit_count >= HEX_DIGIT_LIMIT) begin
              st.phase = PH_ERR_SIZE;
              return 1'b0;
            end
            st.digit_count = st.digit_count + 5'd1;
            st.size_accum  = {st.size_accum[59:0], 4'(digit)};
            return 1'b1;
          end
          if (c != CH_CR && c != CH_LF && c != CH_SEMI) return 1'b0;
          st.size_done = 1'b1;
          if (st.size_accum > limits.max_chunk_len) begin
            st.phase = PH_ERR_SIZE;
            return 1'b0;
          end
          if (c == CH_SEMI) begin
            st.space_count = '0;
            st.phase       = PH_EXT_WS;
          end else if (c == CH_CR) begin
            st.phase = PH_AWAIT_LF;
          end else begin
            if (limits.strict_crlf) return 1'b0;
            st.phase = PH_VALID;
          end
          return 1'b1;
        end
        PH_EXT: begin
          if (c != CH_CR && c != CH_LF) begin
            ext = 1'b1;
            return 1'b1;
          end
          if (c == CH_CR) begin
            st.phase = PH_AWAIT_LF;
            return 1'b1;
          end
          if (limits.strict_crlf) begin
            st.phase = PH_ERR_CRLF;
            return 1'b0;
          end
          st.phase = PH_VALID;
          return 1'b1;
        end
        PH_AWAIT_LF: begin
          if (c == CH_LF) begin
            st.phase = PH_VALID;
            return 1'b1;
          end
          return 1'b0;
        end
        default: return 1'b0;
      endcase
    endfunction

    // Called for every byte transfer into the block.
    function void note_transfer(logic [7:0] c, logic restart);
      result_t want;
      logic    ok;
      logic    ext;
      logic    saturated;
      if (restart) clear_line();
      saturated = (st.line_count == 16'hFFFF);
      if (!saturated) st.line_count = st.line_count + 16'd1;
      if (saturated || st.line_count > limits.max_line_length) st.phase = PH_ERR_LEN;
      ok = advance(c, ext);
      want.accepted    = ok;
      want.phase       = st.phase;
      want.chunk_len   = st.size_accum;
      want.size_known  = st.size_done;
      want.ext_byte    = ext;
      want.header_done = (st.phase == PH_VALID);
      expected_results.insert(expected_results.size(), want);
      transfers++;
      if (!ok) refused++;
      if (ok && want.header_done) headers_done++;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= 40)
          $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
    endfunction

    // Called for every result transfer out of the block.
    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 40)
          $display("%0t: result with nothing expected, expected none, got phase %0d size 0x%0h",
                   $time, got.phase, got.chunk_len);
        return;
      end
      want = expected_results.pop_front();
      checked++;
      compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
      compare_field("phase", 64'(want.phase), 64'(got.phase));
      compare_field("chunk_len", want.chunk_len, got.chunk_len);
      compare_field("size_known", 64'(want.size_known), 64'(got.size_known));
      compare_field("ext_byte", 64'(want.ext_byte), 64'(got.ext_byte));
      compare_field("header_done", 64'(want.header_done), 64'(got.header_done));
    endfunction

    function void finish_check();
      if (expected_results.size() != 0) begin
        $display("%0t: %0d results never arrived, expected 0 outstanding, got %0d",
                 $time, expected_results.size(), expected_results.size());
        failures += expected_results.size();
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_MAX_LINE_LENGTH;
  logic [63:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i   = '0;
  logic        restart_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        accepted_o;
  logic [3:0]  phase_o;
  logic [63:0] chunk_len_o;
  logic        size_known_o;
  logic        ext_byte_o;
  logic        header_done_o;

  chunk_line_tracker line_check = new();

  bit          burst_mode = 1'b0;
  bit          steady_tx  = 1'b0;
  int unsigned rx_hold    = 0;
  int unsigned limit_settings = 0;

  http_chunk_header_parser i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .accepted_o   (accepted_o),
    .phase_o      (phase_o),
    .chunk_len_o  (chunk_len_o),
    .size_known_o (size_known_o),
    .ext_byte_o   (ext_byte_o),
    .header_done_o(header_done_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  // Offers one byte and waits for its transfer. Starts and ends on a falling edge.
  task automatic send_byte(input logic [7:0] c, input logic restart);
    int unsigned gap;
    gap = (burst_mode || steady_tx) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_byte_i  = c;
    restart_i  = restart;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    line_check.note_transfer(c, restart);
    @(negedge clk_i);
  endtask

  // Sends a byte of a line; the first byte restarts the parser, others rarely do.
  task automatic put_byte(input logic [7:0] c, inout logic fresh);
    send_byte(c, fresh || ($urandom_range(0, 99) == 0));
    fresh = 1'b0;
  endtask

  task automatic send_text(input string s, input logic restart_first);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(8'(s[i]), restart_first && (i == 0));
  endtask

  task automatic write_register(input logic [1:0] index, input logic [63:0] data);
    cfg_index_i = index;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    line_check.set_register(index, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Holds the input off until every expected result is in, then lets the pipeline settle.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (line_check.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_limits(input logic [15:0] len, input logic [7:0] ws,
                            input logic [63:0] size_max, input logic strict);
    wait_drained();
    write_register(CFG_MAX_LINE_LENGTH, 64'(len));
    write_register(CFG_MAX_WHITESPACE, 64'(ws));
    write_register(CFG_MAX_CHUNK_LEN, size_max);
    write_register(CFG_STRICT_CRLF, 64'(strict));
    limit_settings++;
  endtask

  // Random bytes biased toward the characters the parser cares about.
  task automatic send_noise(input int unsigned count);
    int unsigned i;
    logic [7:0]  c;
    for (i = 0; i < count; i++) begin
      case ($urandom_range(0, 6))
        0:       c = CH_SPACE;
        1:       c = CH_TAB;
        2:       c = CH_CR;
        3:       c = CH_LF;
        4:       c = CH_SEMI;
        5:       c = hex_char(4'($urandom_range(0, 15)));
        default: c = 8'($urandom_range(0, 255));
      endcase
      send_byte(c, $urandom_range(0, 7) == 0);
    end
  endtask

  // One chunk header line with random content, sometimes broken on purpose.
  task automatic send_line();
    int unsigned r;
    int unsigned count;
    int unsigned i;
    logic [63:0] value;
    logic [7:0]  c;
    logic        fresh;
    fresh     = 1'b1;
    steady_tx = ($urandom_range(0, 6) == 0);

    // Leading blanks, sometimes right at the limit or one past it.
    if ($urandom_range(0, 99) < 85) count = $urandom_range(0, 2);
    else count = line_check.limits.max_whitespace + $urandom_range(0, 1);
    for (i = 0; i < count; i++) put_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, fresh);

    // Hex digits: short, long, full width at or one above the size maximum, full width, empty or too many.
    r     = $urandom_range(0, 99);
    value = {$urandom, $urandom};
    if (r < 55) count = $urandom_range(1, 4);
    else if (r < 75) count = $urandom_range(5, 15);
    else if (r < 85) begin
      count = HEX_DIGIT_LIMIT;
      value = line_check.limits.max_chunk_len + 64'($urandom_range(0, 1));
    end else if (r < 93) count = HEX_DIGIT_LIMIT;
    else if (r < 96) count = 0;
    else count = HEX_DIGIT_LIMIT + 1;
    if (count < HEX_DIGIT_LIMIT) value = value << (4 * (HEX_DIGIT_LIMIT - count));
    for (i = 0; i < count; i++) begin
      put_byte(hex_char(value[63:60]), fresh);
      value = value << 4;
    end
    if ($urandom_range(0, 19) == 0) put_byte(8'($urandom_range(0, 255)), fresh);

    // Optional extension.
    if ($urandom_range(0, 99) < 30) begin
      put_byte(CH_SEMI, fresh);
      if ($urandom_range(0, 99) < 85) count = $urandom_range(0, 2);
      else count = line_check.limits.max_whitespace + $urandom_range(0, 1);
      for (i = 0; i < count; i++) put_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, fresh);
      count = $urandom_range(0, 6);
      for (i = 0; i < count; i++) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_CR || c == CH_LF) c = 8'h78;
        put_byte(c, fresh);
      end
    end

    // Line end: CR LF, bare LF, CR with a stray byte, or nothing at all.
    r = $urandom_range(0, 99);
    if (r < 70) begin
      put_byte(CH_CR, fresh);
      put_byte(CH_LF, fresh);
    end else if (r < 88) begin
      put_byte(CH_LF, fresh);
    end else if (r < 95) begin
      put_byte(CH_CR, fresh);
      put_byte(8'($urandom_range(0, 255)), fresh);
      put_byte(CH_LF, fresh);
    end
    if ($urandom_range(0, 3) == 0) put_byte(8'($urandom_range(0, 255)), fresh);
  endtask

  task automatic run_phase(input logic [15:0] len, input logic [7:0] ws,
                           input logic [63:0] size_max, input logic strict,
                           input int unsigned items, input int unsigned hold);
    int unsigned stop;
    set_limits(len, ws, size_max, strict);
    rx_hold = hold;
    stop    = line_check.transfers + items;
    while (line_check.transfers < stop) begin
      if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 8));
      else send_line();
    end
  endtask

  // Result side: random stalls, quiet stretches and the long hold-off on request.
  initial begin : result_pacing
    int unsigned stall;
    int unsigned cycle;
    bit          steady_rx;
    stall     = 0;
    cycle     = 0;
    steady_rx = 1'b0;
    while (rst_ni !== 1'b1) @(negedge clk_i);
    forever begin
      @(negedge clk_i);
      cycle++;
      if (cycle % 97 == 0) steady_rx = ($urandom_range(0, 4) == 0);
      if (rx_hold > 0) begin
        out_ready_i = 1'b0;
        rx_hold--;
      end else if (burst_mode || steady_rx) begin
        out_ready_i = 1'b1;
      end else if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        out_ready_i = 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.accepted    = accepted_o;
      got.phase       = phase_o;
      got.chunk_len   = chunk_len_o;
      got.size_known  = size_known_o;
      got.ext_byte    = ext_byte_o;
      got.header_done = header_done_o;
      line_check.check_result(got);
    end
  end

  initial begin : stimulus
    int unsigned i;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Plain size line, then a byte after the header is complete.
    send_text("7", 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_text("x", 1'b0);
    // Leading blanks, mixed-case digits, an extension and a stray byte before LF.
    send_text(" \taF; x", 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_text("Z", 1'b0);
    send_byte(CH_LF, 1'b0);
    // A bad first byte still enters the size field; an empty size reads as zero.
    send_byte(8'h00, 1'b1);
    send_byte(CH_LF, 1'b0);

    // Tight limits with strict line ends.
    set_limits(16'd5, 8'd1, 64'h10, 1'b1);
    send_text("  ", 1'b1);
    // Bare LF is refused after the size, and is an error after an extension.
    send_text("10", 1'b1);
    send_byte(CH_LF, 1'b0);
    send_text(";", 1'b0);
    send_byte(CH_LF, 1'b0);
    // Size above the maximum, then a line longer than five bytes.
    send_text("11;", 1'b1);
    send_text("1;aaaa", 1'b1);

    // Random lines under a spread of limit settings.
    run_phase(16'd1024, 8'd8, 64'hFFFF_FFFF, 1'b0, 170, 0);
    run_phase(16'hFFFF, 8'hFF, '1, 1'b1, 170, 0);
    run_phase(16'd0, 8'd0, 64'd0, 1'b0, 40, 0);
    run_phase(16'd12, 8'd1, 64'hFFF, 1'b0, 170, 0);
    run_phase(16'd40, 8'd3, {$urandom, $urandom} >> $urandom_range(0, 63), 1'b1, 170, 150);
    run_phase(16'd200, 8'd2, {$urandom, $urandom} >> $urandom_range(0, 63), 1'b0, 170, 0);
    run_phase(16'd1, 8'hFF, 64'd1, 1'b1, 60, 0);
    run_phase(16'($urandom), 8'($urandom), {$urandom, $urandom}, 1'($urandom), 170, 0);

    // One line running well past a short length limit, back to back.
    set_limits(16'd16, 8'hFF, '1, 1'b0);
    burst_mode = 1'b1;
    for (i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 255)), i == 0);
    burst_mode = 1'b0;

    run_phase(16'd1024, 8'd8, 64'hFFFF_FFFF, 1'b0, 150, 0);

    wait_drained();
    repeat (8) @(negedge clk_i);
    line_check.finish_check();
    $display("Checked %0d results for %0d byte transfers under %0d limit settings.",
             line_check.checked, line_check.transfers, limit_settings);
    $display("Headers completed: %0d, bytes refused: %0d, one back-to-back overlong line.",
             line_check.headers_done, line_check.refused);
    if (line_check.failures == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #24_000_000;
    $display("Timeout with %0d results outstanding", line_check.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
